[rtl/scc_pkg.sv]
// Package for the strongly connected components block.
// Holds default sizes, command codes and the sequencer state type.
// Used by strongly_connected_components_top and scc_checker.
package scc_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;

  localparam int CMD_W = 3;
  localparam int INDEX_W = 12;
  localparam int VALUE_W = 13;
  localparam int RESULT_W = 13;
  localparam int NCOUNT_W = 11;

  localparam logic [CMD_W-1:0] CMD_WR_OFFSET = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_TARGET = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RUN       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RD_COMP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_SIZE   = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_QNODE,
    S_QSIZE,
    S_CK_RD,
    S_CK_CMP,
    S_ET_RD,
    S_ET_CMP,
    S_CLR,
    S_ROOT,
    S_R_CHK,
    S_VOFF0,
    S_VOFF1,
    S_VOFF2,
    S_SCAN,
    S_E_WAIT,
    S_E_CHK,
    S_POP_RD,
    S_POP_WR,
    S_FRAME,
    S_F_WAIT
  } scc_state_t;

endpackage

[rtl/scc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Parameters set width and depth; no package dependency.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/strongly_connected_components_top.sv]
// Top level of the strongly connected components block: loader, query port
// and an iterative Tarjan sequencer. Depends on scc_pkg and scc_ram.
//
//   channel | ports                                        | direction
//   in      | in_valid in_stall in_command in_index in_value | request in
//   out     | out_valid out_stall out_result_value out_status | result out
//   cfg     | cfg_wr_en cfg_wr_data                         | node_count write
//
// Loads and bad requests answer from the request decode; queries go through one RAM read.
// A run checks the row offsets, then the edge targets, clears the node marks,
// then walks the graph over its edges and nodes and pops each finished
// component; the shared RAM read ports set the pace of the walk.
// Reset is synchronous and active low; it clears control state only.
// A stalled result holds; a new request is taken as the old result leaves.
module strongly_connected_components_top
  import scc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [INDEX_W-1:0]  in_index,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RESULT_W-1:0] out_result_value,
  output logic                out_status,
  input  logic                cfg_wr_en,
  input  logic [NCOUNT_W-1:0] cfg_wr_data
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int RO_AW  = CNT_W;
  localparam int OFF_W  = $clog2(MAX_EDGES + 1);
  localparam int EA_W   = $clog2(MAX_EDGES);
  localparam int NI_W   = NODE_W + 1;
  localparam int FR_W   = 3 * NODE_W + 2 * OFF_W;
  localparam int FR_LOW = 0;
  localparam int FR_ORD = NODE_W;
  localparam int FR_END = 2 * NODE_W;
  localparam int FR_NXT = 2 * NODE_W + OFF_W;
  localparam int FR_NOD = 2 * NODE_W + 2 * OFF_W;

  scc_state_t state_r, state_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0] out_value_r, out_value_nxt;
  logic                out_status_r, out_status_nxt;
  logic [NCOUNT_W-1:0] node_count_r;
  logic [CNT_W-1:0]    run_nodes_r, run_nodes_nxt;
  logic [CNT_W-1:0]    comp_total_r, comp_total_nxt;

  logic [CNT_W-1:0]  order_r, order_nxt;
  logic [CNT_W-1:0]  sp_r, sp_nxt;
  logic [CNT_W-1:0]  fp_r, fp_nxt;
  logic [CNT_W-1:0]  root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [OFF_W-1:0]  prev_r, prev_nxt;
  logic [OFF_W-1:0]  e_cur_r, e_cur_nxt;
  logic [OFF_W-1:0]  e_last_r, e_last_nxt;
  logic [NODE_W-1:0] cur_u_r, cur_u_nxt;
  logic [OFF_W-1:0]  cur_next_r, cur_next_nxt;
  logic [OFF_W-1:0]  cur_end_r, cur_end_nxt;
  logic [NODE_W-1:0] cur_ord_r, cur_ord_nxt;
  logic [NODE_W-1:0] cur_low_r, cur_low_nxt;
  logic [NODE_W-1:0] v_r, v_nxt;

  // RAM ports
  logic              ro_we;
  logic [RO_AW-1:0]  ro_waddr, ro_raddr;
  logic [OFF_W-1:0]  ro_wdata, ro_rdata;
  logic              et_we;
  logic [EA_W-1:0]   et_waddr, et_raddr;
  logic [NODE_W-1:0] et_wdata, et_rdata;
  logic              ni_we;
  logic [NODE_W-1:0] ni_waddr, ni_raddr;
  logic [NI_W-1:0]   ni_wdata, ni_rdata;
  logic              os_we;
  logic [NODE_W-1:0] os_waddr, os_raddr;
  logic [0:0]        os_wdata, os_rdata;
  logic              cs_we;
  logic [NODE_W-1:0] cs_waddr, cs_raddr;
  logic [NODE_W-1:0] cs_wdata, cs_rdata;
  logic              fr_we;
  logic [NODE_W-1:0] fr_waddr, fr_raddr;
  logic [FR_W-1:0]   fr_wdata, fr_rdata;
  logic              nc_we;
  logic [NODE_W-1:0] nc_waddr, nc_raddr;
  logic [NODE_W-1:0] nc_wdata, nc_rdata;
  logic              sz_we;
  logic [NODE_W-1:0] sz_waddr, sz_raddr;
  logic [CNT_W-1:0]  sz_wdata, sz_rdata;

  // request decode
  logic        in_accept, out_take;
  logic [31:0] idx32, val32, n32;
  logic [CNT_W-1:0] n_cnt;
  logic        ld_off_ok, ld_tgt_ok, q_comp_ok, q_size_ok, run_big, run_empty;

  // walk conditions
  logic ck_bad, ck_last, et_done, et_bad, clr_last, root_done, r_vis;
  logic scan_more, scan_root, e_vis, e_lower, pop_last, fp_zero;
  logic [NODE_W-1:0] par_low;

  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign idx32 = 32'(in_index);
  assign val32 = 32'(in_value);
  assign n32   = 32'(node_count_r);
  assign n_cnt = CNT_W'(node_count_r);

  assign ld_off_ok = (idx32 <= n32) && (idx32 <= 32'(MAX_NODES)) && (val32 <= 32'(MAX_EDGES));
  assign ld_tgt_ok = (idx32 < 32'(MAX_EDGES)) && (val32 < n32) && (val32 < 32'(MAX_NODES));
  assign q_comp_ok = (idx32 < 32'(run_nodes_r)) && (idx32 < 32'(MAX_NODES));
  assign q_size_ok = (idx32 < 32'(comp_total_r)) && (idx32 < 32'(MAX_NODES));
  assign run_big   = n32 > 32'(MAX_NODES);
  assign run_empty = node_count_r == '0;

  assign ck_bad    = (32'(ro_rdata) > 32'(MAX_EDGES)) || ((cnt_r != '0) && (ro_rdata < prev_r));
  assign ck_last   = cnt_r == n_cnt;
  assign et_done   = e_cur_r >= e_last_r;
  assign et_bad    = 32'(et_rdata) >= n32;
  assign clr_last  = cnt_r == (n_cnt - CNT_W'(1));
  assign root_done = root_r == n_cnt;
  assign r_vis     = ni_rdata[NI_W-1];
  assign scan_more = cur_next_r < cur_end_r;
  assign scan_root = cur_low_r == cur_ord_r;
  assign e_vis     = ni_rdata[NI_W-1];
  assign e_lower   = os_rdata[0] && (ni_rdata[NODE_W-1:0] < cur_low_r);
  assign pop_last  = (cs_rdata == cur_u_r) || (sp_r == '0);
  assign fp_zero   = fp_r == '0;
  assign par_low   = fr_rdata[FR_LOW +: NODE_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_command == CMD_RD_COMP && q_comp_ok) state_nxt = S_QNODE;
          else if (in_command == CMD_RD_SIZE && q_size_ok) state_nxt = S_QSIZE;
          else if (in_command == CMD_RUN && !run_big && !run_empty) state_nxt = S_CK_RD;
        end
      end
      S_QNODE:  state_nxt = S_IDLE;
      S_QSIZE:  state_nxt = S_IDLE;
      S_CK_RD:  state_nxt = S_CK_CMP;
      S_CK_CMP: begin
        if (ck_bad) state_nxt = S_IDLE;
        else if (ck_last) state_nxt = S_ET_RD;
        else state_nxt = S_CK_RD;
      end
      S_ET_RD:  state_nxt = et_done ? S_CLR : S_ET_CMP;
      S_ET_CMP: state_nxt = et_bad ? S_IDLE : S_ET_RD;
      S_CLR:    state_nxt = clr_last ? S_ROOT : S_CLR;
      S_ROOT:   state_nxt = root_done ? S_IDLE : S_R_CHK;
      S_R_CHK:  state_nxt = r_vis ? S_ROOT : S_VOFF0;
      S_VOFF0:  state_nxt = S_VOFF1;
      S_VOFF1:  state_nxt = S_VOFF2;
      S_VOFF2:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_more) state_nxt = S_E_WAIT;
        else if (scan_root) state_nxt = S_POP_RD;
        else state_nxt = S_FRAME;
      end
      S_E_WAIT: state_nxt = S_E_CHK;
      S_E_CHK:  state_nxt = e_vis ? S_SCAN : S_VOFF0;
      S_POP_RD: state_nxt = S_POP_WR;
      S_POP_WR: state_nxt = pop_last ? S_FRAME : S_POP_RD;
      S_FRAME:  state_nxt = fp_zero ? S_ROOT : S_F_WAIT;
      S_F_WAIT: state_nxt = S_SCAN;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_take;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    run_nodes_nxt  = run_nodes_r;
    comp_total_nxt = comp_total_r;
    order_nxt      = order_r;
    sp_nxt         = sp_r;
    fp_nxt         = fp_r;
    root_nxt       = root_r;
    cnt_nxt        = cnt_r;
    size_nxt       = size_r;
    prev_nxt       = prev_r;
    e_cur_nxt      = e_cur_r;
    e_last_nxt     = e_last_r;
    cur_u_nxt      = cur_u_r;
    cur_next_nxt   = cur_next_r;
    cur_end_nxt    = cur_end_r;
    cur_ord_nxt    = cur_ord_r;
    cur_low_nxt    = cur_low_r;
    v_nxt          = v_r;

    ro_we = 1'b0; ro_waddr = idx32[RO_AW-1:0]; ro_wdata = val32[OFF_W-1:0];
    ro_raddr = RO_AW'(cnt_r);
    et_we = 1'b0; et_waddr = idx32[EA_W-1:0]; et_wdata = val32[NODE_W-1:0];
    et_raddr = e_cur_r[EA_W-1:0];
    ni_we = 1'b0; ni_waddr = cnt_r[NODE_W-1:0]; ni_wdata = '0;
    ni_raddr = root_r[NODE_W-1:0];
    os_we = 1'b0; os_waddr = cnt_r[NODE_W-1:0]; os_wdata = 1'b0;
    os_raddr = et_rdata;
    cs_we = 1'b0; cs_waddr = sp_r[NODE_W-1:0]; cs_wdata = root_r[NODE_W-1:0];
    cs_raddr = sp_r[NODE_W-1:0] - NODE_W'(1);
    fr_we = 1'b0; fr_waddr = fp_r[NODE_W-1:0];
    fr_wdata = {cur_u_r, cur_next_r, cur_end_r, cur_ord_r, cur_low_r};
    fr_raddr = fp_r[NODE_W-1:0] - NODE_W'(1);
    nc_we = 1'b0; nc_waddr = cs_rdata; nc_wdata = comp_total_r[NODE_W-1:0];
    nc_raddr = idx32[NODE_W-1:0];
    sz_we = 1'b0; sz_waddr = comp_total_r[NODE_W-1:0]; sz_wdata = size_r + CNT_W'(1);
    sz_raddr = idx32[NODE_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_value_nxt  = '0;
          out_status_nxt = 1'b0;
          case (in_command)
            CMD_WR_OFFSET: begin
              out_valid_nxt  = 1'b1;
              ro_we          = ld_off_ok;
              out_status_nxt = !ld_off_ok;
            end
            CMD_WR_TARGET: begin
              out_valid_nxt  = 1'b1;
              et_we          = ld_tgt_ok;
              out_status_nxt = !ld_tgt_ok;
            end
            CMD_RUN: begin
              cnt_nxt = '0;
              if (run_big) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
                comp_total_nxt = '0;
                run_nodes_nxt  = '0;
              end else if (run_empty) begin
                out_valid_nxt  = 1'b1;
                comp_total_nxt = '0;
                run_nodes_nxt  = '0;
              end
            end
            CMD_RD_COMP: begin
              out_valid_nxt  = !q_comp_ok;
              out_status_nxt = !q_comp_ok;
            end
            CMD_RD_SIZE: begin
              out_valid_nxt  = !q_size_ok;
              out_status_nxt = !q_size_ok;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b1;
            end
          endcase
        end
      end
      S_QNODE: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = RESULT_W'(nc_rdata);
      end
      S_QSIZE: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = RESULT_W'(sz_rdata);
      end
      S_CK_CMP: begin
        prev_nxt = ro_rdata;
        if (cnt_r == '0) e_cur_nxt = ro_rdata;
        if (ck_bad) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          comp_total_nxt = '0;
          run_nodes_nxt  = '0;
        end else if (ck_last) begin
          e_last_nxt = ro_rdata;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ET_RD: begin
        cnt_nxt = '0;
      end
      S_ET_CMP: begin
        e_cur_nxt = e_cur_r + OFF_W'(1);
        if (et_bad) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          comp_total_nxt = '0;
          run_nodes_nxt  = '0;
        end
      end
      S_CLR: begin
        ni_we = 1'b1;
        os_we = 1'b1;
        cnt_nxt        = cnt_r + CNT_W'(1);
        root_nxt       = '0;
        order_nxt      = '0;
        sp_nxt         = '0;
        fp_nxt         = '0;
        comp_total_nxt = '0;
      end
      S_ROOT: begin
        if (root_done) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_value_nxt  = RESULT_W'(comp_total_r);
          run_nodes_nxt  = n_cnt;
        end
      end
      S_R_CHK: begin
        if (r_vis) begin
          root_nxt = root_r + CNT_W'(1);
        end else begin
          // open the root frame
          ni_we    = 1'b1;
          ni_waddr = root_r[NODE_W-1:0];
          ni_wdata = {1'b1, order_r[NODE_W-1:0]};
          os_we    = 1'b1;
          os_waddr = root_r[NODE_W-1:0];
          os_wdata = 1'b1;
          cs_we    = 1'b1;
          cs_wdata = root_r[NODE_W-1:0];
          sp_nxt      = sp_r + CNT_W'(1);
          order_nxt   = order_r + CNT_W'(1);
          cur_u_nxt   = root_r[NODE_W-1:0];
          cur_ord_nxt = order_r[NODE_W-1:0];
          cur_low_nxt = order_r[NODE_W-1:0];
        end
      end
      S_VOFF0: begin
        ro_raddr = RO_AW'(cur_u_r);
      end
      S_VOFF1: begin
        ro_raddr     = RO_AW'(cur_u_r) + RO_AW'(1);
        cur_next_nxt = ro_rdata;
      end
      S_VOFF2: begin
        cur_end_nxt = ro_rdata;
      end
      S_SCAN: begin
        et_raddr = cur_next_r[EA_W-1:0];
        if (scan_more) cur_next_nxt = cur_next_r + OFF_W'(1);
        size_nxt = '0;
      end
      S_E_WAIT: begin
        v_nxt    = et_rdata;
        ni_raddr = et_rdata;
        os_raddr = et_rdata;
      end
      S_E_CHK: begin
        if (!e_vis) begin
          // push the parent frame, descend into v
          fr_we    = 1'b1;
          fp_nxt   = fp_r + CNT_W'(1);
          ni_we    = 1'b1;
          ni_waddr = v_r;
          ni_wdata = {1'b1, order_r[NODE_W-1:0]};
          os_we    = 1'b1;
          os_waddr = v_r;
          os_wdata = 1'b1;
          cs_we    = 1'b1;
          cs_wdata = v_r;
          sp_nxt      = sp_r + CNT_W'(1);
          order_nxt   = order_r + CNT_W'(1);
          cur_u_nxt   = v_r;
          cur_ord_nxt = order_r[NODE_W-1:0];
          cur_low_nxt = order_r[NODE_W-1:0];
        end else if (e_lower) begin
          cur_low_nxt = ni_rdata[NODE_W-1:0];
        end
      end
      S_POP_RD: begin
        sp_nxt = sp_r - CNT_W'(1);
      end
      S_POP_WR: begin
        os_we    = 1'b1;
        os_waddr = cs_rdata;
        os_wdata = 1'b0;
        nc_we    = 1'b1;
        size_nxt = size_r + CNT_W'(1);
        if (pop_last) begin
          sz_we          = 1'b1;
          comp_total_nxt = comp_total_r + CNT_W'(1);
        end
      end
      S_FRAME: begin
        if (fp_zero) root_nxt = root_r + CNT_W'(1);
        else fp_nxt = fp_r - CNT_W'(1);
      end
      S_F_WAIT: begin
        // resume the parent, fold in the child's low link
        cur_u_nxt    = fr_rdata[FR_NOD +: NODE_W];
        cur_next_nxt = fr_rdata[FR_NXT +: OFF_W];
        cur_end_nxt  = fr_rdata[FR_END +: OFF_W];
        cur_ord_nxt  = fr_rdata[FR_ORD +: NODE_W];
        cur_low_nxt  = (cur_low_r < par_low) ? cur_low_r : par_low;
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_take;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= '0;
      run_nodes_r  <= '0;
      comp_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      run_nodes_r  <= run_nodes_nxt;
      comp_total_r <= comp_total_nxt;
      if (cfg_wr_en) node_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    order_r      <= order_nxt;
    sp_r         <= sp_nxt;
    fp_r         <= fp_nxt;
    root_r       <= root_nxt;
    cnt_r        <= cnt_nxt;
    size_r       <= size_nxt;
    prev_r       <= prev_nxt;
    e_cur_r      <= e_cur_nxt;
    e_last_r     <= e_last_nxt;
    cur_u_r      <= cur_u_nxt;
    cur_next_r   <= cur_next_nxt;
    cur_end_r    <= cur_end_nxt;
    cur_ord_r    <= cur_ord_nxt;
    cur_low_r    <= cur_low_nxt;
    v_r          <= v_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

  scc_ram #(.WIDTH(OFF_W), .DEPTH(MAX_NODES + 1)) u_row_offsets (
    .clk(clk), .we(ro_we), .waddr(ro_waddr), .wdata(ro_wdata),
    .raddr(ro_raddr), .rdata(ro_rdata)
  );

  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_targets (
    .clk(clk), .we(et_we), .waddr(et_waddr), .wdata(et_wdata),
    .raddr(et_raddr), .rdata(et_rdata)
  );

  scc_ram #(.WIDTH(NI_W), .DEPTH(MAX_NODES)) u_node_info (
    .clk(clk), .we(ni_we), .waddr(ni_waddr), .wdata(ni_wdata),
    .raddr(ni_raddr), .rdata(ni_rdata)
  );

  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_on_stack (
    .clk(clk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
    .raddr(os_raddr), .rdata(os_rdata)
  );

  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_comp_stack (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  scc_ram #(.WIDTH(FR_W), .DEPTH(MAX_NODES)) u_call_frames (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_comp (
    .clk(clk), .we(nc_we), .waddr(nc_waddr), .wdata(nc_wdata),
    .raddr(nc_raddr), .rdata(nc_rdata)
  );

  scc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_comp_size (
    .clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
    .raddr(sz_raddr), .rdata(sz_rdata)
  );

endmodule

[rtl/scc_checker.sv]
// Port-level checks for the strongly connected components block.
// Depends on scc_pkg; bound to strongly_connected_components_top below.
module scc_checker
  import scc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [CMD_W-1:0]    in_command,
  input logic                out_valid,
  input logic                out_stall,
  input logic [RESULT_W-1:0] out_result_value,
  input logic                out_status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_status))
    else $error("stalled result changed");

  // an error result carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_value == '0)
    else $error("error result not zero");

  // a load answers in the next cycle with zero
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_WR_OFFSET || in_command == CMD_WR_TARGET)
    |=> out_valid && out_result_value == '0)
    else $error("load result missing");

  // an unknown command answers in the next cycle with an error
  a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command > CMD_RD_SIZE |=> out_valid && out_status)
    else $error("unknown command not flagged");

endmodule

bind strongly_connected_components_top scc_checker u_scc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_command(in_command),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_result_value(out_result_value),
  .out_status(out_status)
);
